// ----- hw/rtl/ecpi_pkg.sv -----
// Shared constants and types of the exact color palette indexer.
package ecpi_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int GRAY_LEVELS         = 256;
  localparam int CHAN_W              = 8;
  localparam int COLOR_W             = 3 * CHAN_W;
  localparam int INDEX_W             = 8;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [INDEX_W-1:0] index_t;

  // Gray table requests; level addresses both the read and the write.
  typedef struct packed {
    logic  clear;
    logic  rd_en;
    logic  wr_en;
    chan_t level;
  } gray_req_t;

  // Palette memory requests.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } pal_req_t;

endpackage

// ----- hw/rtl/ecpi_if.sv -----
// Valid/ready channel interfaces for pixel words and index words.
interface ecpi_in_if;
  logic                  valid;
  logic                  ready;
  logic                  start_of_image;
  ecpi_pkg::chan_t       red;
  ecpi_pkg::chan_t       green;
  ecpi_pkg::chan_t       blue;

  modport source (output valid, output start_of_image, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input start_of_image, input red, input green,
                  input blue, output ready);
endinterface

interface ecpi_out_if;
  logic                  valid;
  logic                  ready;
  ecpi_pkg::index_t      palette_index;
  logic                  new_entry;
  logic                  overflow;

  modport source (output valid, output palette_index, output new_entry,
                  output overflow, input ready);
  modport sink   (input valid, input palette_index, input new_entry,
                  input overflow, output ready);
endinterface

// ----- hw/rtl/exact_color_palette_indexer.sv -----
// Top level: sequencer that maps RGB pixels to exact palette indexes.
//
// Pixel words enter on in_ch (start_of_image, red, green, blue); one index
// word leaves on out_ch per pixel (palette_index, new_entry, overflow).
// in_ch.ready is high only while the sequencer is idle: one pixel at a time.
// A gray pixel is looked up in the gray table. A colored pixel walks the
// palette memory one entry per cycle through a single comparator, stopping at
// a hit or after the last filled entry (the fill count is at most PALETTE_ENTRIES).
// A pixel on an overflowed palette is answered without a lookup. The next pixel
// can be taken in the cycle after the result word is loaded.
// A new color is appended at index count and flagged with new_entry; a new
// color on a full palette sets the sticky overflow flag, after which every
// pixel answers index 0 until start_of_image clears the palette.
// Reset clears the fill count, the gray valid bits and the overflow flag;
// no clearing pass is needed. A stalled out_ch holds the result word in its
// output register; one more pixel is still taken and worked, then the
// sequencer waits in its done state and accepts nothing new.
module exact_color_palette_indexer #(
  parameter int PALETTE_ENTRIES = ecpi_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  ecpi_in_if.sink             in_ch,
  ecpi_out_if.source          out_ch
);
  import ecpi_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(PALETTE_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_GRAY     = 5'b00100,
    S_SEARCH   = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  color_t        color_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  index_t        res_idx_r, res_idx_nxt;
  logic          res_new_r, res_new_nxt;
  logic          out_valid_r, out_valid_nxt;
  index_t        out_idx_r;
  logic          out_new_r;
  logic          out_ovf_r;

  logic          accept;
  logic          is_gray;
  logic          miss;
  logic          pal_match;
  logic          gray_hit;
  logic [AW-1:0] gray_index;
  gray_req_t     gray_req;
  pal_req_t      pal_req;

  assign accept  = in_ch.valid && in_ch.ready;
  assign is_gray = (color_r[23:16] == color_r[15:8]) && (color_r[23:16] == color_r[7:0]);

  ecpi_gray_tbl #(.AW(AW)) u_gray (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (gray_req),
    .wr_index (count_r[AW-1:0]),
    .hit      (gray_hit),
    .index    (gray_index)
  );

  ecpi_palette #(.ENTRIES(PALETTE_ENTRIES), .AW(AW)) u_palette (
    .clk     (clk),
    .req     (pal_req),
    .rd_addr (k_r[AW-1:0]),
    .wr_addr (count_r[AW-1:0]),
    .key     (color_r),
    .match   (pal_match)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_idx_nxt    = res_idx_r;
    res_new_nxt    = res_new_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    miss           = 1'b0;
    gray_req.clear = 1'b0;
    gray_req.rd_en = 1'b0;
    gray_req.wr_en = 1'b0;
    gray_req.level = color_r[23:16];
    pal_req.rd_en  = 1'b0;
    pal_req.wr_en  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // start of image: drop the palette before handling this pixel
          if (in_ch.start_of_image) begin
            count_nxt      = '0;
            ovf_nxt        = 1'b0;
            gray_req.clear = 1'b1;
          end
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (ovf_r) begin
          res_idx_nxt = '0;
          res_new_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else if (is_gray) begin
          gray_req.rd_en = 1'b1;
          state_nxt      = S_GRAY;
        end else begin
          k_nxt     = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SEARCH;
        end
      end
      S_GRAY: begin
        if (gray_hit) begin
          res_idx_nxt = INDEX_W'(gray_index);
          res_new_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          miss = 1'b1;
        end
      end
      S_SEARCH: begin
        if (pend_r && pal_match) begin
          res_idx_nxt = INDEX_W'(pend_idx_r);
          res_new_nxt = 1'b0;
          pend_nxt    = 1'b0;
          state_nxt   = S_DONE;
        end else if (k_r < count_r) begin
          // issue the next entry; its compare lands next cycle
          pal_req.rd_en = 1'b1;
          pend_nxt      = 1'b1;
          pend_idx_nxt  = k_r[AW-1:0];
          k_nxt         = k_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          miss     = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (miss) begin
      if (count_r == FULL) begin
        ovf_nxt     = 1'b1;
        res_idx_nxt = '0;
        res_new_nxt = 1'b0;
      end else begin
        pal_req.wr_en  = 1'b1;
        gray_req.wr_en = is_gray;
        res_idx_nxt    = INDEX_W'(count_r[AW-1:0]);
        res_new_nxt    = 1'b1;
        count_nxt      = count_r + CW'(1);
      end
      state_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    if (accept) begin
      color_r <= {in_ch.red, in_ch.green, in_ch.blue};
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
      out_idx_r <= res_idx_r;
      out_new_r <= res_new_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.palette_index = out_idx_r;
  assign out_ch.new_entry     = out_new_r;
  assign out_ch.overflow      = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("palette fill count above capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == FULL))
    else $error("overflow set while palette not full");

  a_new_not_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_ovf_r))
    else $error("new entry reported together with overflow");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (k_r <= count_r))
    else $error("search index ran past the palette fill");

endmodule

// ----- hw/rtl/ecpi_gray_tbl.sv -----
// Gray-level to palette index table with per-level valid bits.
module ecpi_gray_tbl #(
  parameter int AW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ecpi_pkg::gray_req_t   req,
  input  logic [AW-1:0]         wr_index,
  output logic                  hit,
  output logic [AW-1:0]         index
);
  import ecpi_pkg::*;

  logic [AW-1:0]          mem [GRAY_LEVELS];
  logic [GRAY_LEVELS-1:0] vld_r;
  logic                   hit_r;
  logic [AW-1:0]          index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clear) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.level] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.level] <= wr_index;
    end
    if (req.rd_en) begin
      index_r <= mem[req.level];
      hit_r   <= vld_r[req.level];
    end
  end

  assign hit   = hit_r;
  assign index = index_r;

endmodule

// ----- hw/rtl/ecpi_palette.sv -----
// Palette color memory with registered read and the shared color comparator.
module ecpi_palette #(
  parameter int ENTRIES = 256,
  parameter int AW      = 8
) (
  input  logic                 clk,
  input  ecpi_pkg::pal_req_t   req,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  ecpi_pkg::color_t     key,
  output logic                 match
);
  import ecpi_pkg::*;

  color_t mem [ENTRIES];
  color_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= key;
    end
    if (req.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // One compare per cycle against the most recently read entry.
  assign match = (rdata_r == key);

endmodule

// ----- dv/tb_exact_color_palette_indexer.sv -----
// Testbench for the exact color palette indexer: directed, overflow, back-pressure and random.
module tb_exact_color_palette_indexer;
  import ecpi_pkg::*;

  localparam int PAL_CAP      = PALETTE_ENTRIES_DEF;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int TAIL_CYCLES  = 300;

  typedef struct packed {
    index_t idx;
    logic   fresh;
    logic   ovf;
  } pal_result_t;

  logic clk;
  logic rst_n;

  ecpi_in_if  in_ch();
  ecpi_out_if out_ch();

  exact_color_palette_indexer #(.PALETTE_ENTRIES(PAL_CAP)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predicted palette state
  color_t pal_color [PAL_CAP];
  int     pal_fill;
  index_t gray_slot [GRAY_LEVELS];
  bit     gray_known [GRAY_LEVELS];
  bit     pal_overflow;

  pal_result_t pending_idx_q[$];

  int errors;
  int cycles;
  int n_pixels;
  int n_fresh;
  int n_ovf;
  int n_images;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_left;

  function automatic pal_result_t index_pixel(logic sof, chan_t r, chan_t g, chan_t b);
    pal_result_t res;
    color_t      color;
    bit          hit;
    bit          is_gray;
    color = {r, g, b};
    res = '0;
    hit = 1'b0;
    if (sof) begin
      pal_fill = 0;
      foreach (gray_known[i]) gray_known[i] = 1'b0;
      pal_overflow = 1'b0;
    end
    if (!pal_overflow) begin
      is_gray = (r == g) && (r == b);
      if (is_gray) begin
        if (gray_known[r]) begin
          res.idx = gray_slot[r];
          hit = 1'b1;
        end
      end else begin
        for (int k = 0; k < pal_fill && !hit; k++) begin
          if (pal_color[k] == color) begin
            res.idx = index_t'(k);
            hit = 1'b1;
          end
        end
      end
      if (!hit) begin
        if (pal_fill >= PAL_CAP) begin
          pal_overflow = 1'b1;
        end else begin
          res.idx = index_t'(pal_fill);
          pal_color[pal_fill] = color;
          if (is_gray) begin
            gray_slot[r]  = index_t'(pal_fill);
            gray_known[r] = 1'b1;
          end
          pal_fill++;
          res.fresh = 1'b1;
        end
      end
    end
    res.ovf = pal_overflow;
    return res;
  endfunction

  function automatic color_t rand_color(bit want_gray);
    chan_t lvl;
    lvl = chan_t'($urandom_range(255));
    if (want_gray) return {lvl, lvl, lvl};
    return color_t'($urandom);
  endfunction

  // Drive one pixel word and hold it until accepted
  task automatic send_pixel(input logic sof, input chan_t r, input chan_t g, input chan_t b);
    pal_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.start_of_image = sof;
    in_ch.red            = r;
    in_ch.green          = g;
    in_ch.blue           = b;
    do @(posedge clk); while (!in_ch.ready);
    res = index_pixel(sof, r, g, b);
    pending_idx_q.push_back(res);
    n_pixels++;
    if (sof) n_images++;
    @(negedge clk);
  endtask

  task automatic send_color(input logic sof, input color_t c);
    send_pixel(sof, c[23:16], c[15:8], c[7:0]);
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_idx_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pal_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_idx_q.size() == 0) begin
        $display("%0t: result with nothing pending: index %0d new %0b overflow %0b",
                 $time, out_ch.palette_index, out_ch.new_entry, out_ch.overflow);
        errors++;
      end else begin
        want = pending_idx_q.pop_front();
        if (out_ch.palette_index !== want.idx) begin
          $display("%0t: palette_index expected %0d got %0d", $time, want.idx,
                   out_ch.palette_index);
          errors++;
        end
        if (out_ch.new_entry !== want.fresh) begin
          $display("%0t: new_entry expected %0b got %0b", $time, want.fresh,
                   out_ch.new_entry);
          errors++;
        end
        if (out_ch.overflow !== want.ovf) begin
          $display("%0t: overflow expected %0b got %0b", $time, want.ovf, out_ch.overflow);
          errors++;
        end
        if (want.fresh) n_fresh++;
        if (want.ovf) n_ovf++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d words pending", $time, pending_idx_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Extremes, gray and colored paths, hits and restarts of the image
  task automatic test_directed();
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hff, 8'hff, 8'hff);
    send_pixel(1'b0, 8'hff, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h00, 8'hff, 8'h00);
    send_pixel(1'b0, 8'h00, 8'h00, 8'hff);
    send_pixel(1'b0, 8'hff, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h80, 8'h80, 8'h80);
    send_pixel(1'b0, 8'h00, 8'h00, 8'hff);
    send_pixel(1'b0, 8'hff, 8'hff, 8'h00);
    send_pixel(1'b0, 8'hff, 8'hff, 8'hff);
    send_pixel(1'b1, 8'hff, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hff, 8'h00, 8'h00);
    send_pixel(1'b0, 8'h01, 8'h01, 8'h01);
    send_pixel(1'b0, 8'h01, 8'h01, 8'h00);
    send_pixel(1'b0, 8'h01, 8'h01, 8'h01);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hff, 8'hff, 8'hfe);
    send_pixel(1'b0, 8'h7f, 8'h80, 8'h7f);
    send_pixel(1'b1, 8'h80, 8'h7f, 8'h7f);
    drain_results();
  endtask

  // Fill with every gray level, then overflow on a colored pixel
  task automatic test_overflow_gray();
    for (int lvl = 0; lvl < GRAY_LEVELS; lvl++) begin
      send_pixel(lvl == 0, chan_t'(lvl), chan_t'(lvl), chan_t'(lvl));
    end
    send_pixel(1'b0, 8'hff, 8'hff, 8'hff);
    send_pixel(1'b0, 8'h01, 8'h02, 8'h03);
    send_pixel(1'b0, 8'h05, 8'h05, 8'h05);
    send_pixel(1'b0, 8'h01, 8'h02, 8'h03);
    send_pixel(1'b1, 8'h07, 8'h08, 8'h09);
    send_pixel(1'b0, 8'h05, 8'h05, 8'h05);
    drain_results();
  endtask

  // Fill with colored pixels, search to the last entry, overflow on a gray one
  task automatic test_overflow_colored();
    for (int i = 0; i < PAL_CAP; i++) begin
      send_pixel(i == 0, chan_t'(i), chan_t'(255 - i), chan_t'(i) ^ 8'h33);
    end
    send_pixel(1'b0, 8'hff, 8'h00, 8'hff ^ 8'h33);
    send_pixel(1'b0, 8'h00, 8'hff, 8'h33);
    send_pixel(1'b0, 8'h09, 8'h09, 8'h09);
    send_pixel(1'b0, 8'h00, 8'hff, 8'h33);
    send_pixel(1'b1, 8'h09, 8'h09, 8'h09);
    send_pixel(1'b0, 8'h00, 8'hff, 8'h33);
    drain_results();
  endtask

  // Hold the receiver for a long stretch while words keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 400;
    send_pixel(1'b1, 8'h10, 8'h20, 8'h30);
    for (int i = 0; i < 8; i++) send_color(1'b0, rand_color(i[0]));
    drain_results();
  endtask

  // Images drawn from small color pools, with noise and one overflowing image
  task automatic test_random(input int n_items, input int s_idle, input int r_idle);
    color_t pool [300];
    int     pool_sz;
    int     img_len;
    int     sent;
    int     pick;
    bit     big;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    big  = 1'b1;
    while (sent < n_items) begin
      if (big) begin
        pool_sz = 300;
        img_len = 320;
      end else begin
        pool_sz = $urandom_range(1, 32);
        img_len = $urandom_range(4, 80);
      end
      for (int i = 0; i < pool_sz; i++) pool[i] = rand_color($urandom_range(99) < 40);
      for (int p = 0; p < img_len; p++) begin
        pick = $urandom_range(99);
        if (big && p < pool_sz) send_color(p == 0, pool[p]);
        else if (pick < 85) send_color(p == 0 || pick < 2, pool[$urandom_range(pool_sz - 1)]);
        else if (pick < 95) send_color(p == 0, rand_color(1'b0));
        else send_color(p == 0, rand_color(1'b1));
        sent++;
      end
      big = 1'b0;
      if ($urandom_range(9) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.start_of_image = 1'b0;
    in_ch.red            = '0;
    in_ch.green          = '0;
    in_ch.blue           = '0;
    out_ch.ready         = 1'b0;
    errors    = 0;
    cycles    = 0;
    n_pixels  = 0;
    n_fresh   = 0;
    n_ovf     = 0;
    n_images  = 0;
    hold_req  = 0;
    hold_left = 0;
    pal_fill  = 0;
    pal_overflow = 1'b0;
    foreach (gray_known[i]) gray_known[i] = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 68;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_overflow_gray();
    test_overflow_colored();
    test_random(470, 31, 68);
    test_random(470, 68, 31);
    test_random(460, 0, 0);
    test_backpressure();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d pixels over %0d images: %0d new entries, %0d overflowed words",
             n_pixels, n_images, n_fresh, n_ovf);
    $display("Gray and colored paths, full palettes, restarts and output stalls exercised");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
